### sv/epp_pkg.sv
// Shared widths, register indexes, geometry bundle and square-root step
// for the ellipse perimeter point generator. No dependencies.
package epp_pkg;

    localparam int COORD_BITS = 12;
    localparam int R   = COORD_BITS - 1;
    localparam int NW  = 4 * R;
    localparam int IW  = 14;
    localparam int OW  = COORD_BITS + 1;
    localparam int LW  = (IW > COORD_BITS + 2) ? IW : COORD_BITS + 2;
    localparam int CIW = 3;

    localparam logic [CIW-1:0] REG_LEFT   = CIW'(0);
    localparam logic [CIW-1:0] REG_TOP    = CIW'(1);
    localparam logic [CIW-1:0] REG_WIDTH  = CIW'(2);
    localparam logic [CIW-1:0] REG_HEIGHT = CIW'(3);

    typedef enum logic [2:0] {
        GS_IDLE,
        GS_SQR,
        GS_NUM,
        GS_DIV,
        GS_ROOT,
        GS_SEGS
    } geom_state_t;

    typedef struct packed {
        logic [R-1:0]   rx;
        logic [R-1:0]   ry;
        logic [2*R-1:0] rx2;
        logic [2*R-1:0] ry2;
        logic [OW-1:0]  cx;
        logic [OW-1:0]  cy;
        logic [R-1:0]   bx;
        logic [R-1:0]   by;
        logic [LW-1:0]  sb;
        logic [LW-1:0]  sc;
        logic [LW-1:0]  sd;
        logic [LW-1:0]  se;
        logic [LW-1:0]  len;
        logic           rpos;
    } geom_t;

    typedef struct packed {
        logic [NW-1:0] n;
        logic [NW-1:0] res;
    } sq_t;

    function automatic sq_t sqrt_step(sq_t s, logic [NW-1:0] b);
        sq_t           o;
        logic [NW-1:0] t;
        t = s.res + b;
        if (s.n >= t) begin
            o.n   = s.n - t;
            o.res = (s.res >> 1) + b;
        end else begin
            o.n   = s.n;
            o.res = s.res >> 1;
        end
        return o;
    endfunction

endpackage

### sv/epp_geom.sv
// Configuration registers and the iterative unit that derives radii, center,
// octant breakpoints and segment starts. Depends on epp_pkg.
module epp_geom (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [epp_pkg::CIW-1:0]       cfg_idx,
    input  logic [epp_pkg::COORD_BITS-1:0] cfg_wr_data,
    output epp_pkg::geom_t                geom,
    output logic                          busy
);
    localparam int CW = $clog2(epp_pkg::NW);

    epp_pkg::geom_state_t state_reg, state_next;

    logic [epp_pkg::COORD_BITS-1:0] left_reg, top_reg, width_reg, height_reg;
    logic [epp_pkg::R-1:0]          rx, ry, bx_reg, by_reg;
    logic [2*epp_pkg::R-1:0]        rx2_reg, ry2_reg;
    logic [2*epp_pkg::R:0]          den_reg, rem_reg, rem_next;
    logic [2*epp_pkg::R+1:0]        rem_sh;
    logic                           ge;
    logic [epp_pkg::NW-1:0]         quo_reg, bit_reg;
    logic [epp_pkg::OW-1:0]         cx_reg, cy_reg;
    logic [epp_pkg::LW-1:0]         sb_reg, sc_reg, sd_reg, se_reg, len_reg;
    logic [epp_pkg::LW-1:0]         bxl, byl;
    logic [CW-1:0]                  cnt_reg;
    logic                           axis_reg;
    logic                           wr_hit;
    epp_pkg::sq_t                   sq_reg, sq_next;

    assign rx     = width_reg[epp_pkg::COORD_BITS-1:1];
    assign ry     = height_reg[epp_pkg::COORD_BITS-1:1];
    assign wr_hit = cfg_wr_en && (cfg_idx <= epp_pkg::REG_HEIGHT);
    assign rem_sh = {rem_reg, quo_reg[epp_pkg::NW-1]};
    assign ge     = rem_sh >= {1'b0, den_reg};
    assign rem_next = ge ? rem_sh[2*epp_pkg::R:0] - den_reg : rem_sh[2*epp_pkg::R:0];
    assign sq_next  = epp_pkg::sqrt_step(sq_reg, bit_reg);
    assign bxl = epp_pkg::LW'(bx_reg);
    assign byl = epp_pkg::LW'(by_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= epp_pkg::GS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            epp_pkg::GS_IDLE: state_next = epp_pkg::GS_IDLE;
            epp_pkg::GS_SQR:  state_next = epp_pkg::GS_NUM;
            epp_pkg::GS_NUM:  state_next = epp_pkg::GS_DIV;
            epp_pkg::GS_DIV: begin
                if (cnt_reg == CW'(epp_pkg::NW - 1)) state_next = epp_pkg::GS_ROOT;
            end
            epp_pkg::GS_ROOT: begin
                if (cnt_reg == CW'(2 * epp_pkg::R - 1)) begin
                    state_next = axis_reg ? epp_pkg::GS_SEGS : epp_pkg::GS_NUM;
                end
            end
            epp_pkg::GS_SEGS: state_next = epp_pkg::GS_IDLE;
            default:          state_next = epp_pkg::GS_IDLE;
        endcase
        if (wr_hit) state_next = epp_pkg::GS_SQR;
    end

    assign busy = (state_reg != epp_pkg::GS_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg   <= '0;
            top_reg    <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            cnt_reg    <= '0;
            axis_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_idx)
                    epp_pkg::REG_LEFT:   left_reg   <= cfg_wr_data;
                    epp_pkg::REG_TOP:    top_reg    <= cfg_wr_data;
                    epp_pkg::REG_WIDTH:  width_reg  <= cfg_wr_data;
                    epp_pkg::REG_HEIGHT: height_reg <= cfg_wr_data;
                    default: ;
                endcase
            end
            unique case (state_reg)
                epp_pkg::GS_SQR: begin
                    rx2_reg  <= rx * rx;
                    ry2_reg  <= ry * ry;
                    cx_reg   <= epp_pkg::OW'(left_reg) + epp_pkg::OW'(rx);
                    cy_reg   <= epp_pkg::OW'(top_reg) + epp_pkg::OW'(ry);
                    axis_reg <= 1'b0;
                end
                epp_pkg::GS_NUM: begin
                    quo_reg <= axis_reg ? ry2_reg * ry2_reg : rx2_reg * rx2_reg;
                    den_reg <= {1'b0, rx2_reg} + {1'b0, ry2_reg};
                    rem_reg <= '0;
                    cnt_reg <= '0;
                end
                epp_pkg::GS_DIV: begin
                    rem_reg <= rem_next;
                    quo_reg <= {quo_reg[epp_pkg::NW-2:0], ge};
                    if (cnt_reg == CW'(epp_pkg::NW - 1)) begin
                        cnt_reg    <= '0;
                        sq_reg.n   <= {quo_reg[epp_pkg::NW-2:0], ge};
                        sq_reg.res <= '0;
                        bit_reg    <= epp_pkg::NW'(1) << (epp_pkg::NW - 2);
                    end else begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                end
                epp_pkg::GS_ROOT: begin
                    sq_reg  <= sq_next;
                    bit_reg <= bit_reg >> 2;
                    if (cnt_reg == CW'(2 * epp_pkg::R - 1)) begin
                        cnt_reg  <= '0;
                        axis_reg <= 1'b1;
                        if (axis_reg) begin
                            by_reg <= sq_next.res[epp_pkg::R-1:0];
                        end else begin
                            bx_reg <= sq_next.res[epp_pkg::R-1:0];
                        end
                    end else begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                end
                epp_pkg::GS_SEGS: begin
                    sb_reg  <= bxl + epp_pkg::LW'(1);
                    sc_reg  <= bxl + (byl << 1) + epp_pkg::LW'(2);
                    sd_reg  <= (bxl << 1) + bxl + (byl << 1) + epp_pkg::LW'(3);
                    se_reg  <= (bxl << 1) + bxl + (byl << 2) + epp_pkg::LW'(4);
                    len_reg <= (bxl << 2) + (byl << 2) + epp_pkg::LW'(4);
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        geom.rx   = rx;
        geom.ry   = ry;
        geom.rx2  = rx2_reg;
        geom.ry2  = ry2_reg;
        geom.cx   = cx_reg;
        geom.cy   = cy_reg;
        geom.bx   = bx_reg;
        geom.by   = by_reg;
        geom.sb   = sb_reg;
        geom.sc   = sc_reg;
        geom.sd   = sd_reg;
        geom.se   = se_reg;
        geom.len  = len_reg;
        geom.rpos = (rx != '0) && (ry != '0);
    end

endmodule

### sv/epp_pipe.sv
// Per-item pipeline: segment decode, offset operand, pipelined square root
// and pipelined division, then the final coordinate. Depends on epp_pkg.
module epp_pipe (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      accept,
    input  logic [epp_pkg::IW-1:0]    idx,
    input  epp_pkg::geom_t            geom,
    output logic                      out_vld,
    output logic [epp_pkg::OW-1:0]    out_x,
    output logic [epp_pkg::OW-1:0]    out_y,
    output logic                      out_pv,
    output logic                      out_last
);
    localparam int NQ = 2 * epp_pkg::R;
    localparam int ND = epp_pkg::R;

    typedef enum logic [2:0] {SEG_A, SEG_B, SEG_C, SEG_D, SEG_E} seg_t;

    typedef struct packed {
        logic                   pv;
        logic                   last;
        logic                   off_on_y;
        logic                   off_neg;
        logic [epp_pkg::OW-1:0] direct;
        logic [epp_pkg::OW-1:0] base;
    } ctl_t;

    typedef struct packed {
        logic                   vld;
        ctl_t                   ctl;
        logic [epp_pkg::NW-1:0] a;
        logic [epp_pkg::NW-1:0] b;
    } stage_t;

    logic                     i_vld_reg;
    logic [epp_pkg::LW-1:0]   i_idx_reg;

    logic                     c1_vld_reg, c1_pv_reg, c1_last_reg;
    seg_t                     c1_seg_reg;
    logic [epp_pkg::LW-1:0]   c1_k_reg;

    seg_t                     seg_next;
    logic [epp_pkg::LW-1:0]   start_next;

    logic                     c2_vld_reg;
    ctl_t                     c2_ctl_reg, c2_ctl_next;
    logic [epp_pkg::R-1:0]    c2_m_reg;
    logic [epp_pkg::LW-1:0]   mw;
    logic [epp_pkg::R-1:0]    m_next;
    logic                     neg;

    logic                     c3_vld_reg;
    ctl_t                     c3_ctl_reg;
    logic [2*epp_pkg::R-1:0]  c3_d_reg;

    stage_t                   sq_reg [0:NQ];
    stage_t                   dv_reg [1:ND];

    logic [epp_pkg::R-1:0]    q;
    logic [epp_pkg::OW-1:0]   offc;
    ctl_t                     fc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            i_vld_reg <= 1'b0;
        end else if (en) begin
            i_vld_reg <= accept;
            i_idx_reg <= epp_pkg::LW'(idx);
        end
    end

    always_comb begin
        if (i_idx_reg < geom.sb) begin
            seg_next = SEG_A; start_next = '0;
        end else if (i_idx_reg < geom.sc) begin
            seg_next = SEG_B; start_next = geom.sb;
        end else if (i_idx_reg < geom.sd) begin
            seg_next = SEG_C; start_next = geom.sc;
        end else if (i_idx_reg < geom.se) begin
            seg_next = SEG_D; start_next = geom.sd;
        end else begin
            seg_next = SEG_E; start_next = geom.se;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c1_vld_reg <= 1'b0;
        end else if (en) begin
            c1_vld_reg  <= i_vld_reg;
            c1_pv_reg   <= geom.rpos && (i_idx_reg < geom.len);
            c1_last_reg <= geom.rpos && (i_idx_reg == geom.len - epp_pkg::LW'(1));
            c1_seg_reg  <= seg_next;
            c1_k_reg    <= i_idx_reg - start_next;
        end
    end

    always_comb begin
        mw  = '0;
        neg = 1'b0;
        c2_ctl_next.pv   = c1_pv_reg;
        c2_ctl_next.last = c1_last_reg;
        unique case (c1_seg_reg)
            SEG_A: begin
                mw = c1_k_reg;
            end
            SEG_B: begin
                neg = c1_k_reg < epp_pkg::LW'(geom.by);
                mw  = neg ? epp_pkg::LW'(geom.by) - c1_k_reg
                          : c1_k_reg - epp_pkg::LW'(geom.by);
            end
            SEG_C: begin
                neg = c1_k_reg > epp_pkg::LW'(geom.bx);
                mw  = neg ? c1_k_reg - epp_pkg::LW'(geom.bx)
                          : epp_pkg::LW'(geom.bx) - c1_k_reg;
            end
            SEG_D: begin
                neg = c1_k_reg > epp_pkg::LW'(geom.by);
                mw  = neg ? c1_k_reg - epp_pkg::LW'(geom.by)
                          : epp_pkg::LW'(geom.by) - c1_k_reg;
            end
            SEG_E: begin
                neg = 1'b1;
                mw  = epp_pkg::LW'(geom.bx) - c1_k_reg;
            end
            default: mw = '0;
        endcase
        m_next = mw[epp_pkg::R-1:0];
        c2_ctl_next.off_on_y = (c1_seg_reg == SEG_A) || (c1_seg_reg == SEG_C)
                               || (c1_seg_reg == SEG_E);
        c2_ctl_next.off_neg  = (c1_seg_reg == SEG_A) || (c1_seg_reg == SEG_D)
                               || (c1_seg_reg == SEG_E);
        if (c2_ctl_next.off_on_y) begin
            c2_ctl_next.base   = geom.cy;
            c2_ctl_next.direct = neg ? geom.cx - epp_pkg::OW'(m_next)
                                     : geom.cx + epp_pkg::OW'(m_next);
        end else begin
            c2_ctl_next.base   = geom.cx;
            c2_ctl_next.direct = neg ? geom.cy - epp_pkg::OW'(m_next)
                                     : geom.cy + epp_pkg::OW'(m_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c2_vld_reg <= 1'b0;
            c3_vld_reg <= 1'b0;
        end else if (en) begin
            c2_vld_reg <= c1_vld_reg;
            c2_ctl_reg <= c2_ctl_next;
            c2_m_reg   <= m_next;
            c3_vld_reg <= c2_vld_reg;
            c3_ctl_reg <= c2_ctl_reg;
            c3_d_reg   <= (c2_ctl_reg.off_on_y ? geom.rx2 : geom.ry2) - c2_m_reg * c2_m_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_reg[0].vld <= 1'b0;
        end else if (en) begin
            sq_reg[0].vld <= c3_vld_reg;
            sq_reg[0].ctl <= c3_ctl_reg;
            sq_reg[0].a   <= (c3_ctl_reg.off_on_y ? geom.ry2 : geom.rx2) * c3_d_reg;
            sq_reg[0].b   <= '0;
        end
    end

    for (genvar i = 0; i < NQ; i++) begin : g_sqrt
        localparam logic [epp_pkg::NW-1:0] BIT = epp_pkg::NW'(1) << (epp_pkg::NW - 2 - 2 * i);
        epp_pkg::sq_t s_in, s_out;
        always_comb begin
            s_in.n   = sq_reg[i].a;
            s_in.res = sq_reg[i].b;
            s_out    = epp_pkg::sqrt_step(s_in, BIT);
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_reg[i+1].vld <= 1'b0;
            end else if (en) begin
                sq_reg[i+1].vld <= sq_reg[i].vld;
                sq_reg[i+1].ctl <= sq_reg[i].ctl;
                sq_reg[i+1].a   <= s_out.n;
                sq_reg[i+1].b   <= s_out.res;
            end
        end
    end

    for (genvar j = 0; j < ND; j++) begin : g_div
        localparam int SH = ND - 1 - j;
        stage_t                 cur;
        logic [epp_pkg::NW-1:0] dsh;
        logic [epp_pkg::NW-1:0] quo;
        logic                   take;
        if (j == 0) begin : g_head
            always_comb begin
                cur   = sq_reg[NQ];
                cur.a = sq_reg[NQ].b;
                cur.b = '0;
            end
        end else begin : g_tail
            assign cur = dv_reg[j];
        end
        assign dsh  = epp_pkg::NW'(cur.ctl.off_on_y ? geom.rx : geom.ry) << SH;
        assign take = cur.a >= dsh;
        always_comb begin
            quo     = cur.b;
            quo[SH] = take;
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_reg[j+1].vld <= 1'b0;
            end else if (en) begin
                dv_reg[j+1].vld <= cur.vld;
                dv_reg[j+1].ctl <= cur.ctl;
                dv_reg[j+1].a   <= take ? cur.a - dsh : cur.a;
                dv_reg[j+1].b   <= quo;
            end
        end
    end

    assign fc   = dv_reg[ND].ctl;
    assign q    = dv_reg[ND].b[epp_pkg::R-1:0];
    assign offc = fc.off_neg ? fc.base - epp_pkg::OW'(q) : fc.base + epp_pkg::OW'(q);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld <= 1'b0;
        end else if (en) begin
            out_vld  <= dv_reg[ND].vld;
            out_pv   <= fc.pv;
            out_last <= fc.pv && fc.last;
            if (!fc.pv) begin
                out_x <= '0;
                out_y <= '0;
            end else if (fc.off_on_y) begin
                out_x <= fc.direct;
                out_y <= offc;
            end else begin
                out_x <= offc;
                out_y <= fc.direct;
            end
        end
    end

endmodule

### sv/ellipse_perimeter_points_core.sv
// Top level of the ellipse perimeter point generator.
// Depends on epp_pkg, epp_geom and epp_pipe.
//
//   Channel  Handshake          Payload
//   s_       s_valid/s_ready    s_point_index
//   m_       m_valid/m_ready    m_point_x, m_point_y, m_point_valid, m_last_point
//   cfg_     cfg_wr_en          cfg_idx, cfg_wr_data
//
// One item per cycle while the output is not stalled and the geometry unit is idle;
// items pass the square-root stages (one root bit each), then the divider stages.
// After each write to one of the four registers the geometry unit runs, one divide
// or root bit per cycle, with s_ready low.
// A stalled output item holds the whole pipeline; nothing is dropped.
module ellipse_perimeter_points_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [epp_pkg::CIW-1:0]        cfg_idx,
    input  logic [epp_pkg::COORD_BITS-1:0] cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [epp_pkg::IW-1:0]         s_point_index,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [epp_pkg::OW-1:0]         m_point_x,
    output logic [epp_pkg::OW-1:0]         m_point_y,
    output logic                           m_point_valid,
    output logic                           m_last_point
);
    epp_pkg::geom_t geom;
    logic           busy;
    logic           en;

    assign en      = !m_valid || m_ready;
    assign s_ready = en && !busy;

    epp_geom u_geom (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_idx     (cfg_idx),
        .cfg_wr_data (cfg_wr_data),
        .geom        (geom),
        .busy        (busy)
    );

    epp_pipe u_pipe (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .accept   (s_valid && s_ready),
        .idx      (s_point_index),
        .geom     (geom),
        .out_vld  (m_valid),
        .out_x    (m_point_x),
        .out_y    (m_point_y),
        .out_pv   (m_point_valid),
        .out_last (m_last_point)
    );

endmodule

### sv/epp_checker.sv
// Port-level checks for the ellipse perimeter point generator and the bind
// that attaches them to the top level. Depends on epp_pkg.
module epp_port_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           cfg_wr_en,
    input logic [epp_pkg::CIW-1:0]        cfg_idx,
    input logic                           s_ready,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [epp_pkg::OW-1:0]         m_point_x,
    input logic [epp_pkg::OW-1:0]         m_point_y,
    input logic                           m_point_valid,
    input logic                           m_last_point
);
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_point_valid) |->
        (m_point_x == '0 && m_point_y == '0 && !m_last_point))
        else $error("Invalid point carries nonzero fields.");

    a_last_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last_point) |-> m_point_valid)
        else $error("Last point flagged on an invalid point.");

    a_cfg_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_wr_en && cfg_idx <= epp_pkg::REG_HEIGHT) |=> !s_ready)
        else $error("Input accepted while geometry is recomputed.");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
        (m_valid && $stable(m_point_x) && $stable(m_point_y)))
        else $error("Stalled output item changed.");

endmodule

bind ellipse_perimeter_points_core epp_port_checker u_epp_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_idx       (cfg_idx),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_point_x     (m_point_x),
    .m_point_y     (m_point_y),
    .m_point_valid (m_point_valid),
    .m_last_point  (m_last_point)
);

### verif/epp_checker.sv
// Checker for the ellipse perimeter point generator: watches both channels and the
// register port, predicts each point and compares results. Depends on epp_pkg.
module epp_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [epp_pkg::CIW-1:0]        cfg_idx,
    input  logic [epp_pkg::COORD_BITS-1:0] cfg_wr_data,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic [epp_pkg::IW-1:0]         s_point_index,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [epp_pkg::OW-1:0]         m_point_x,
    input  logic [epp_pkg::OW-1:0]         m_point_y,
    input  logic                           m_point_valid,
    input  logic                           m_last_point,
    output int                             pending_points,
    output int                             error_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [epp_pkg::OW-1:0] x;
        logic [epp_pkg::OW-1:0] y;
        logic                   on_curve;
        logic                   closing;
    } pixel_t;

    logic [epp_pkg::COORD_BITS-1:0] left_q, top_q, width_q, height_q;
    pixel_t                         expected_pixels[$];

    assign pending_points = expected_pixels.size();

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n    = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic longint unsigned span(longint unsigned m, longint unsigned ra,
                                             longint unsigned rb);
        longint unsigned d;
        d = (m * m <= ra * ra) ? ra * ra - m * m : 0;
        return int_sqrt(rb * rb * d) / ra;
    endfunction

    function automatic pixel_t trace_point(logic [epp_pkg::IW-1:0] idx_in);
        pixel_t          p;
        longint unsigned idx, rx, ry, den, bx, by, len, cx, cy, sb, sc, sd, se, k, m;
        longint unsigned px, py;
        idx = idx_in;
        rx  = width_q >> 1;
        ry  = height_q >> 1;
        px  = 0;
        py  = 0;
        p.on_curve = 1'b0;
        p.closing  = 1'b0;
        if (rx != 0 && ry != 0) begin
            den = rx * rx + ry * ry;
            bx  = int_sqrt((rx * rx * rx * rx) / den);
            by  = int_sqrt((ry * ry * ry * ry) / den);
            len = 4 * bx + 4 * by + 4;
            cx  = left_q + rx;
            cy  = top_q + ry;
            sb  = bx + 1;
            sc  = sb + 2 * by + 1;
            sd  = sc + 2 * bx + 1;
            se  = sd + 2 * by + 1;
            if (idx < len) begin
                p.on_curve = 1'b1;
                p.closing  = (idx == len - 1);
                if (idx < sb) begin
                    px = cx + idx;
                    py = cy - span(idx, rx, ry);
                end else if (idx < sc) begin
                    k  = idx - sb;
                    m  = (k < by) ? by - k : k - by;
                    px = cx + span(m, ry, rx);
                    py = (k < by) ? cy - m : cy + m;
                end else if (idx < sd) begin
                    k  = idx - sc;
                    m  = (k > bx) ? k - bx : bx - k;
                    px = (k > bx) ? cx - m : cx + m;
                    py = cy + span(m, rx, ry);
                end else if (idx < se) begin
                    k  = idx - sd;
                    m  = (k > by) ? k - by : by - k;
                    px = cx - span(m, ry, rx);
                    py = (k > by) ? cy - m : cy + m;
                end else begin
                    m  = bx - (idx - se);
                    px = cx - m;
                    py = cy - span(m, rx, ry);
                end
            end
        end
        p.x = px[epp_pkg::OW-1:0];
        p.y = py[epp_pkg::OW-1:0];
        return p;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t mismatch %s: got %0d, expected %0d", $time, what, got, want);
        error_count++;
    endtask

    initial error_count = 0;

    always @(posedge aclk) begin
        pixel_t want;
        if (!aresetn) begin
            left_q   <= '0;
            top_q    <= '0;
            width_q  <= '0;
            height_q <= '0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch("unexpected item, x", m_point_x, -1);
                end else begin
                    want = expected_pixels.pop_front();
                    if (m_point_x !== want.x) report_mismatch("point_x", m_point_x, want.x);
                    if (m_point_y !== want.y) report_mismatch("point_y", m_point_y, want.y);
                    if (m_point_valid !== want.on_curve)
                        report_mismatch("point_valid", m_point_valid, want.on_curve);
                    if (m_last_point !== want.closing)
                        report_mismatch("last_point", m_last_point, want.closing);
                end
            end
            if (s_valid && s_ready) expected_pixels.push_back(trace_point(s_point_index));
            if (cfg_wr_en) begin
                case (cfg_idx)
                    epp_pkg::REG_LEFT:   left_q   <= cfg_wr_data;
                    epp_pkg::REG_TOP:    top_q    <= cfg_wr_data;
                    epp_pkg::REG_WIDTH:  width_q  <= cfg_wr_data;
                    epp_pkg::REG_HEIGHT: height_q <= cfg_wr_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

### verif/testbench.sv
// Top of the ellipse perimeter point regression: clock, reset, stimulus and verdict.
// Depends on epp_pkg, ellipse_perimeter_points_core and epp_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int                      SETTLE_CYCLES = 100;
    localparam int                      CYCLE_LIMIT   = 600000;
    localparam logic [epp_pkg::CIW-1:0] REG_UNUSED    = epp_pkg::CIW'(5);

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [epp_pkg::CIW-1:0]        cfg_idx = '0;
    logic [epp_pkg::COORD_BITS-1:0] cfg_wr_data = '0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic [epp_pkg::IW-1:0]         s_point_index = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [epp_pkg::OW-1:0]         m_point_x, m_point_y;
    logic                           m_point_valid, m_last_point;
    int                             pending_points, error_count;
    int                             send_idle_pct = 0;
    int                             recv_stall_pct = 0;
    int                             cycle_count = 0;
    int                             span_hint = 16;

    ellipse_perimeter_points_core u_top (.*);

    epp_checker u_checker (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(negedge aclk) m_ready = ($urandom_range(0, 99) >= recv_stall_pct);

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("ellipse_perimeter_points_core regression: fail");
            $finish;
        end
    end

    task automatic send_index(logic [epp_pkg::IW-1:0] idx);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid       = 1'b1;
        s_point_index = idx;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic drain_points();
        s_valid = 1'b0;
        while (pending_points != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(logic [epp_pkg::CIW-1:0] idx,
                             logic [epp_pkg::COORD_BITS-1:0] data);
        cfg_wr_en   = 1'b1;
        cfg_idx     = idx;
        cfg_wr_data = data;
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
    endtask

    task automatic set_rect(int l, int t, int w, int h);
        drain_points();
        write_reg(epp_pkg::REG_LEFT, epp_pkg::COORD_BITS'(l));
        write_reg(epp_pkg::REG_TOP, epp_pkg::COORD_BITS'(t));
        write_reg(epp_pkg::REG_WIDTH, epp_pkg::COORD_BITS'(w));
        write_reg(epp_pkg::REG_HEIGHT, epp_pkg::COORD_BITS'(h));
        write_reg(REG_UNUSED, epp_pkg::COORD_BITS'($urandom));
        span_hint = 2 * (w + h) + 8;
    endtask

    initial begin
        int w, h, pick;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        send_index('0);
        set_rect(100, 50, 6, 4);
        for (int i = 0; i < 18; i++) send_index(epp_pkg::IW'(i));
        send_index('1);
        set_rect(4095, 4095, 4095, 4095);
        send_index('0);
        send_index(14'd11583);
        send_index(14'h2aaa);
        set_rect(0, 0, 1, 4095);
        send_index('0);
        send_index(14'h1555);

        for (int seg = 0; seg < 16; seg++) begin
            case (seg % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            pick = $urandom_range(0, 9);
            w = (pick < 6) ? $urandom_range(0, 64) : (pick < 9) ? $urandom_range(0, 4095) : 4095;
            h = (pick < 6) ? $urandom_range(0, 64) : (pick < 9) ? $urandom_range(0, 4095) : 4095;
            if (seg == 5) begin w = 2; h = 2; end
            set_rect($urandom, $urandom, w % 4096, h % 4096);
            for (int n = 0; n < 115; n++) begin
                if (n == 60 && seg == 3) drain_points();
                if ($urandom_range(0, 9) < 8) begin
                    send_index(epp_pkg::IW'($urandom_range(0, span_hint) % 16384));
                end else begin
                    send_index(epp_pkg::IW'($urandom));
                end
            end
        end
        drain_points();

        if (error_count == 0) begin
            $display("ellipse_perimeter_points_core regression: pass");
        end else begin
            $display("ellipse_perimeter_points_core regression: fail");
        end
        $finish;
    end

endmodule
